/* rtl/pbp_pkg.sv */
package pbp_pkg;

    // Field widths
    localparam int SLOT_W  = 3;
    localparam int REQ_W   = 16;
    localparam int BAND_W  = 8;
    localparam int NCNT_W  = 4;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 2;

    // Sum of up to fifteen requests, and band count times that sum
    localparam int TOT_W   = REQ_W + NCNT_W;
    localparam int PROD_W  = BAND_W + TOT_W;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_BAND_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_NODE_COUNT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_OWN_SLOT   = 2'd2;

    typedef struct packed {
        logic [SLOT_W-1:0] node_slot;
        logic [REQ_W-1:0]  request_blocks;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] grant_slot;
        logic [BAND_W-1:0] first_band;
        logic [BAND_W-1:0] block_count;
        logic              is_local;
        logic              last;
    } t_grant;

endpackage

/* rtl/proportional_band_partitioner.sv */
// Proportional band partitioner. Each start transfer taken while busy is low
// stores one node request; a request for a slot in use then keeps busy high for
// 1 cycle, and a request for a slot not in use is dropped without raising busy.
// The transfer that completes a round (every slot below node_count has
// reported) starts a partition that keeps busy high until its last result is
// given. The work goes to one shared datapath: a rank pass of n compare-and-add
// steps per slot, n being the slots in use, and two 8-step restoring divisions
// per slot, one quotient bit per cycle. One result per slot is given in slot
// order, each on o_grant for a single cycle marked by o_valid; the receiver
// cannot stall and must take every result as it comes. Configuration is
// sampled when a partition begins.
module proportional_band_partitioner #(
    parameter int MAX_NODES = 8,
    parameter int MAX_BANDS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pbp_pkg::t_req               i_req,
    output logic                        o_valid,
    output pbp_pkg::t_grant             o_grant,
    input  logic                        i_cfg_we,
    input  logic [pbp_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [pbp_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import pbp_pkg::*;

    localparam int SW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int KW = $clog2(BAND_W);
    localparam logic [6:0] NodeCap = 7'(MAX_NODES);
    localparam logic [8:0] BandCap = 9'(MAX_BANDS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_RANK  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    // Configuration registers
    logic [BAND_W-1:0] r_band_count;
    logic [NCNT_W-1:0] r_node_count;
    logic [SLOT_W-1:0] r_own_slot;

    // Request store and round flags
    logic [REQ_W-1:0]     r_req [MAX_NODES];
    logic [MAX_NODES-1:0] r_seen;

    // Sequencer
    logic [2:0]        r_state, n_state;
    logic [NCNT_W-1:0] r_i, n_i;
    logic [NCNT_W-1:0] r_j, n_j;
    logic [KW-1:0]     r_k, n_k;
    logic              r_phase, n_phase;
    logic              r_valid, n_valid;

    // Datapath
    logic [PROD_W-1:0] r_rem, n_rem;
    logic [PROD_W-1:0] r_dsr, n_dsr;
    logic [BAND_W-1:0] r_q, n_q;
    logic [BAND_W-1:0] r_fhi, n_fhi;
    logic [BAND_W-1:0] r_flo, n_flo;
    logic [TOT_W-1:0]  r_total, n_total;
    logic              r_nz, n_nz;
    logic [TOT_W-1:0]  r_prefix, n_prefix;
    logic [REQ_W-1:0]  r_wi, n_wi;
    logic [BAND_W-1:0] r_start, n_start;
    logic [BAND_W-1:0] r_bands, n_bands;
    logic [NCNT_W-1:0] r_n, n_n;
    logic [SLOT_W-1:0] r_own, n_own;
    t_grant            r_grant, n_grant;

    logic              accept;
    logic              slot_ok;
    logic              round_done;
    logic [NCNT_W-1:0] node_eff;
    logic [BAND_W-1:0] band_eff;
    logic [SW-1:0]     rd_addr;
    logic [REQ_W-1:0]  rd_data;
    logic [REQ_W-1:0]  rd_weight;
    logic              ge;
    logic [BAND_W-1:0] q_shift;
    logic [BAND_W-1:0] cnt;
    logic [TOT_W-1:0]  mul_op;
    logic [BAND_W-1:0] end_band;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_grant = r_grant;
    assign accept  = start && !busy;

    // Clamp node and band counts to their usable range
    always_comb begin
        if (r_node_count == '0) begin
            node_eff = NCNT_W'(1);
        end else if ({3'b000, r_node_count} > NodeCap) begin
            node_eff = NCNT_W'(MAX_NODES);
        end else begin
            node_eff = r_node_count;
        end
        if ({1'b0, r_band_count} > BandCap) begin
            band_eff = BandCap[BAND_W-1:0];
        end else begin
            band_eff = r_band_count;
        end
    end

    assign slot_ok = ({1'b0, i_req.node_slot} < node_eff);

    // Round is complete when no slot in use is missing
    always_comb begin
        round_done = 1'b1;
        for (int k = 0; k < MAX_NODES; k++) begin
            if (k < int'(node_eff) && !r_seen[k]) begin
                round_done = 1'b0;
            end
        end
    end

    // Single read port of the request store
    assign rd_addr   = (r_state == S_LOAD) ? SW'(r_i) : SW'(r_j);
    assign rd_data   = r_req[rd_addr];
    assign rd_weight = r_nz ? rd_data : REQ_W'(1);

    // Shared divider step and run length
    assign ge       = (r_rem >= r_dsr);
    assign q_shift  = {r_q[BAND_W-2:0], ge};
    assign cnt      = r_fhi - r_flo;
    assign mul_op   = r_phase ? (r_prefix - TOT_W'(r_wi)) : r_prefix;
    assign end_band = r_grant.first_band + r_grant.block_count;

    // Sequencer and datapath next state
    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_phase  = r_phase;
        n_valid  = 1'b0;
        n_rem    = r_rem;
        n_dsr    = r_dsr;
        n_q      = r_q;
        n_fhi    = r_fhi;
        n_flo    = r_flo;
        n_total  = r_total;
        n_nz     = r_nz;
        n_prefix = r_prefix;
        n_wi     = r_wi;
        n_start  = r_start;
        n_bands  = r_bands;
        n_n      = r_n;
        n_own    = r_own;
        n_grant  = r_grant;
        case (r_state)
            S_IDLE: begin
                if (accept && slot_ok) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // Latch configuration for the whole partition
                if (round_done) begin
                    n_bands = band_eff;
                    n_n     = node_eff;
                    n_own   = r_own_slot;
                    n_j     = '0;
                    n_total = '0;
                    n_nz    = 1'b0;
                    n_state = S_SUM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SUM: begin
                // Accumulate total; fall back to equal weights on all zero
                n_total = r_total + TOT_W'(rd_data);
                n_nz    = r_nz || (rd_data != '0);
                n_j     = r_j + 1'b1;
                if (r_j == r_n - 1'b1) begin
                    if (!n_nz) begin
                        n_total = TOT_W'(r_n);
                    end
                    n_i     = '0;
                    n_start = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_wi     = rd_weight;
                n_j      = '0;
                n_prefix = '0;
                n_phase  = 1'b0;
                n_state  = S_RANK;
            end
            S_RANK: begin
                // Add weights of slots sorted at or before this one
                if (rd_weight < r_wi || (rd_weight == r_wi && r_j <= r_i)) begin
                    n_prefix = r_prefix + TOT_W'(rd_weight);
                end
                n_j = r_j + 1'b1;
                if (r_j == r_n - 1'b1) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_rem   = PROD_W'(r_bands) * PROD_W'(mul_op);
                n_dsr   = PROD_W'(r_total) << (BAND_W - 1);
                n_q     = '0;
                n_k     = KW'(BAND_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                // One quotient bit per cycle
                if (ge) begin
                    n_rem = r_rem - r_dsr;
                end
                n_q   = q_shift;
                n_dsr = r_dsr >> 1;
                n_k   = r_k - 1'b1;
                if (r_k == '0) begin
                    if (r_phase) begin
                        n_flo   = q_shift;
                        n_state = S_EMIT;
                    end else begin
                        n_fhi   = q_shift;
                        n_phase = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_EMIT: begin
                n_grant.grant_slot  = r_i[SLOT_W-1:0];
                n_grant.first_band  = r_start;
                n_grant.block_count = cnt;
                n_grant.is_local    = (r_i == {1'b0, r_own});
                n_grant.last        = (r_i == r_n - 1'b1);
                n_valid             = 1'b1;
                n_start             = r_start + cnt;
                if (r_i == r_n - 1'b1) begin
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers, configuration, request store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_phase      <= 1'b0;
            r_valid      <= 1'b0;
            r_seen       <= '0;
            r_band_count <= BAND_W'(100);
            r_node_count <= NCNT_W'(8);
            r_own_slot   <= '0;
            for (int k = 0; k < MAX_NODES; k++) begin
                r_req[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_phase <= n_phase;
            r_valid <= n_valid;
            // Store the request of a slot in use
            if (accept && slot_ok) begin
                r_req[SW'(i_req.node_slot)]  <= i_req.request_blocks;
                r_seen[SW'(i_req.node_slot)] <= 1'b1;
            end
            // Drop all flags once the round is complete
            if (r_state == S_CHECK && round_done) begin
                r_seen <= '0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BAND_COUNT: r_band_count <= i_cfg_wdata;
                    CFG_NODE_COUNT: r_node_count <= i_cfg_wdata[NCNT_W-1:0];
                    CFG_OWN_SLOT:   r_own_slot   <= i_cfg_wdata[SLOT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_dsr    <= n_dsr;
        r_q      <= n_q;
        r_fhi    <= n_fhi;
        r_flo    <= n_flo;
        r_total  <= n_total;
        r_nz     <= n_nz;
        r_prefix <= n_prefix;
        r_wi     <= n_wi;
        r_start  <= n_start;
        r_bands  <= n_bands;
        r_n      <= n_n;
        r_own    <= n_own;
        r_grant  <= n_grant;
    end

    // A result strobe follows only the emit step
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_EMIT)
        else $error("result strobe without emit step");

    // The runs of one partition cover exactly the bands in use
    a_runs_cover_bands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_grant.last) |-> (end_band == r_bands && r_state == S_IDLE))
        else $error("final run does not end at band count");

    // Division leaves a remainder below the divisor
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_DIV && (r_state == S_MUL || r_state == S_EMIT))
        |-> r_rem < PROD_W'(r_total))
        else $error("divider remainder out of range");

    // A completed round clears every received flag
    a_seen_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_CHECK && r_state == S_SUM) |-> r_seen == '0)
        else $error("received flags not cleared at partition start");

endmodule
